>>> src/lsr_pkg.sv
package lsr_pkg;

  localparam int DATA_W = 31;
  localparam int PROD_W = 2 * DATA_W;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [DATA_W-1:0] RESET_MULTIPLIER = DATA_W'(16807);
  localparam logic [DATA_W-1:0] RESET_MODULUS = DATA_W'(2147483647);
  localparam logic [DATA_W-1:0] RESET_QUOTIENT = DATA_W'(127773);
  localparam logic [DATA_W-1:0] RESET_REMAINDER = DATA_W'(2836);
  localparam logic [DATA_W-1:0] RESET_STATE = DATA_W'(1);
  // 2^31-1, scale factor and saturation value
  localparam logic [DATA_W-1:0] SCALE_K = DATA_W'(2147483647);

  localparam logic ACTION_DRAW = 1'b0;
  localparam logic ACTION_LOAD = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MULTIPLIER = 2'd0,
    REG_MODULUS    = 2'd1,
    REG_QUOTIENT   = 2'd2,
    REG_REMAINDER  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] multiplier;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] rem_init;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HL_START,
    ST_HL_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMBINE,
    ST_SCALE_MUL,
    ST_SC_START,
    ST_SC_WAIT,
    ST_BD_START,
    ST_BD_WAIT,
    ST_OUT
  } state_t;

endpackage

>>> src/lsr_if.sv
interface lsr_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lsr_pkg::DATA_W-1:0] seed;
  logic [lsr_pkg::DATA_W-1:0] bound_n;

  modport source(output valid, action, seed, bound_n, input ready);
  modport sink(input valid, action, seed, bound_n, output ready);
endinterface

interface lsr_result_if;
  logic                      valid;
  logic                      ready;
  logic [lsr_pkg::DATA_W-1:0] next_state;
  logic [lsr_pkg::DATA_W-1:0] bounded_value;

  modport source(output valid, next_state, bounded_value, input ready);
  modport sink(input valid, next_state, bounded_value, output ready);
endinterface

>>> src/lsr_cfg.sv
module lsr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lsr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lsr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output lsr_pkg::cfg_t                    cfg
);

  lsr_pkg::reg_idx_t idx;
  logic              wr_en;
  logic [lsr_pkg::DATA_W-1:0] wr_val;
  logic [lsr_pkg::DATA_W-1:0] rd_val;

  assign idx    = lsr_pkg::reg_idx_t'(paddr[lsr_pkg::REG_IDX_W+1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_val = pwdata[lsr_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.multiplier <= lsr_pkg::RESET_MULTIPLIER;
      cfg.modulus    <= lsr_pkg::RESET_MODULUS;
      cfg.quotient   <= lsr_pkg::RESET_QUOTIENT;
      cfg.remainder  <= lsr_pkg::RESET_REMAINDER;
    end else if (wr_en) begin
      unique case (idx)
        lsr_pkg::REG_MULTIPLIER: cfg.multiplier <= wr_val;
        lsr_pkg::REG_MODULUS:    cfg.modulus    <= wr_val;
        lsr_pkg::REG_QUOTIENT:   cfg.quotient   <= wr_val;
        lsr_pkg::REG_REMAINDER:  cfg.remainder  <= wr_val;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lsr_pkg::REG_MULTIPLIER: rd_val = cfg.multiplier;
      lsr_pkg::REG_MODULUS:    rd_val = cfg.modulus;
      lsr_pkg::REG_QUOTIENT:   rd_val = cfg.quotient;
      lsr_pkg::REG_REMAINDER:  rd_val = cfg.remainder;
    endcase
  end

  assign prdata = lsr_pkg::APB_DATA_W'(rd_val);

endmodule

>>> src/lsr_div.sv
module lsr_div (
  input  logic              clk,
  input  logic              rst,
  input  lsr_pkg::div_req_t req,
  output lsr_pkg::div_rsp_t rsp
);

  // restoring divider, one quotient bit per cycle
  // dividend is {rem_init, dividend}; rem_init must be below divisor
  logic [lsr_pkg::DATA_W-1:0] rem;
  logic [lsr_pkg::DATA_W-1:0] quo;
  logic [lsr_pkg::DATA_W-1:0] dsr;
  logic [lsr_pkg::CNT_W-1:0]  count;
  logic                       busy;
  logic                       done;

  logic [lsr_pkg::DATA_W:0]   trial;
  logic [lsr_pkg::DATA_W:0]   diff;
  logic                       fits;

  assign trial = {rem, quo[lsr_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == lsr_pkg::CNT_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        count <= lsr_pkg::CNT_W'(lsr_pkg::DIV_STEPS);
      end else if (busy) begin
        count <= count - lsr_pkg::CNT_W'(1);
        if (count == lsr_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[lsr_pkg::DATA_W-1:0] : trial[lsr_pkg::DATA_W-1:0];
      quo <= {quo[lsr_pkg::DATA_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> src/lehmer_schrage_rng_unit.sv
// Park-Miller generator stepped by Schrage's method. A load item (action 1) copies
// seed into the state and gives no result. A draw item (action 0) uses one 31-bit
// restoring divider, one quotient bit per cycle, three times in a row (state by q,
// the scaled product by m, the scaled value by bound_n), and one 31x31 multiplier is
// used three times between them; a zero q or bound_n and a saturated scale skip their
// division. A finished result waits in an output register, so the next item is taken
// while it is still unread. Registers multiplier, modulus, schrage_quotient and
// schrage_remainder sit at byte addresses 0, 4, 8 and 12 and should be written only
// while the block is idle.
module lehmer_schrage_rng_unit (
  input  logic                           clk,
  input  logic                           rst,
  lsr_cmd_if.sink                        cmd,
  lsr_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lsr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lsr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  lsr_pkg::cfg_t     cfg;
  lsr_pkg::div_req_t div_req;
  lsr_pkg::div_rsp_t div_rsp;
  lsr_pkg::state_t   state, state_next;

  logic [lsr_pkg::DATA_W-1:0] gen_state;
  logic [lsr_pkg::DATA_W-1:0] hi;
  logic [lsr_pkg::DATA_W-1:0] lo;
  logic [lsr_pkg::DATA_W-1:0] bound;
  logic [lsr_pkg::DATA_W-1:0] scaled;
  logic [lsr_pkg::DATA_W-1:0] bounded;
  logic [lsr_pkg::PROD_W-1:0] prod;
  logic [lsr_pkg::PROD_W-1:0] plus;

  logic [lsr_pkg::DATA_W-1:0] mul_a;
  logic [lsr_pkg::DATA_W-1:0] mul_b;
  logic [lsr_pkg::PROD_W-1:0] diff;
  logic                       plus_gt;
  logic [lsr_pkg::DATA_W-1:0] wrapped;
  logic [lsr_pkg::DATA_W-1:0] advanced;

  logic accept;
  logic q_zero;
  logic sat;
  logic bound_zero;
  logic out_free;

  logic                       out_valid;
  logic [lsr_pkg::DATA_W-1:0] out_state;
  logic [lsr_pkg::DATA_W-1:0] out_bounded;

  lsr_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  lsr_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign accept     = cmd.valid && cmd.ready;
  assign q_zero     = (cfg.quotient == '0);
  // scaled value exceeds 2^31-1 exactly when the state is above m
  assign sat        = (cfg.modulus == '0) || (gen_state > cfg.modulus);
  assign bound_zero = (bound == '0);
  assign out_free   = !out_valid || result.ready;

  // a*lo - r*hi, or m minus the shortfall; only the low 31 bits are kept
  assign diff     = plus - prod;
  assign plus_gt  = plus > prod;
  assign wrapped  = cfg.modulus + diff[lsr_pkg::DATA_W-1:0];
  assign advanced = plus_gt ? diff[lsr_pkg::DATA_W-1:0] : wrapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lsr_pkg::ST_IDLE: begin
        if (accept && cmd.action == lsr_pkg::ACTION_DRAW) begin
          state_next = lsr_pkg::ST_HL_START;
        end
      end
      lsr_pkg::ST_HL_START:  state_next = q_zero ? lsr_pkg::ST_MUL_LO : lsr_pkg::ST_HL_WAIT;
      lsr_pkg::ST_HL_WAIT: begin
        if (div_rsp.done) begin
          state_next = lsr_pkg::ST_MUL_LO;
        end
      end
      lsr_pkg::ST_MUL_LO:    state_next = lsr_pkg::ST_MUL_HI;
      lsr_pkg::ST_MUL_HI:    state_next = lsr_pkg::ST_COMBINE;
      lsr_pkg::ST_COMBINE:   state_next = lsr_pkg::ST_SCALE_MUL;
      lsr_pkg::ST_SCALE_MUL: state_next = lsr_pkg::ST_SC_START;
      lsr_pkg::ST_SC_START:  state_next = sat ? lsr_pkg::ST_BD_START : lsr_pkg::ST_SC_WAIT;
      lsr_pkg::ST_SC_WAIT: begin
        if (div_rsp.done) begin
          state_next = lsr_pkg::ST_BD_START;
        end
      end
      lsr_pkg::ST_BD_START:  state_next = bound_zero ? lsr_pkg::ST_OUT : lsr_pkg::ST_BD_WAIT;
      lsr_pkg::ST_BD_WAIT: begin
        if (div_rsp.done) begin
          state_next = lsr_pkg::ST_OUT;
        end
      end
      lsr_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = lsr_pkg::ST_IDLE;
        end
      end
      default: state_next = lsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready        = (state == lsr_pkg::ST_IDLE);
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.dividend = gen_state;
    div_req.divisor  = cfg.quotient;
    mul_a            = gen_state;
    mul_b            = lsr_pkg::SCALE_K;
    unique case (state)
      lsr_pkg::ST_HL_START: begin
        div_req.start = !q_zero;
      end
      lsr_pkg::ST_SC_START: begin
        div_req.start    = !sat;
        div_req.rem_init = prod[lsr_pkg::PROD_W-1:lsr_pkg::DATA_W];
        div_req.dividend = prod[lsr_pkg::DATA_W-1:0];
        div_req.divisor  = cfg.modulus;
      end
      lsr_pkg::ST_BD_START: begin
        div_req.start    = !bound_zero;
        div_req.dividend = scaled;
        div_req.divisor  = bound;
      end
      lsr_pkg::ST_MUL_LO: begin
        mul_a = cfg.multiplier;
        mul_b = lo;
      end
      lsr_pkg::ST_MUL_HI: begin
        mul_a = cfg.remainder;
        mul_b = hi;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= lsr_pkg::RESET_STATE;
    end else if (accept && cmd.action == lsr_pkg::ACTION_LOAD) begin
      gen_state <= cmd.seed;
    end else if (state == lsr_pkg::ST_COMBINE) begin
      gen_state <= advanced;
    end
  end

  always_ff @(posedge clk) begin
    prod <= lsr_pkg::PROD_W'(mul_a) * lsr_pkg::PROD_W'(mul_b);
    if (accept) begin
      bound <= cmd.bound_n;
    end
    unique case (state)
      lsr_pkg::ST_HL_START: begin
        hi <= '0;
        lo <= gen_state;
      end
      lsr_pkg::ST_HL_WAIT: begin
        hi <= div_rsp.quotient;
        lo <= div_rsp.remainder;
      end
      lsr_pkg::ST_MUL_HI:   plus <= prod;
      lsr_pkg::ST_SC_START: scaled <= lsr_pkg::SCALE_K;
      lsr_pkg::ST_SC_WAIT:  scaled <= div_rsp.quotient;
      lsr_pkg::ST_BD_START: bounded <= scaled;
      lsr_pkg::ST_BD_WAIT:  bounded <= div_rsp.remainder;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lsr_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lsr_pkg::ST_OUT && out_free) begin
      out_state   <= gen_state;
      out_bounded <= bounded;
    end
  end

  assign result.valid         = out_valid;
  assign result.next_state    = out_state;
  assign result.bounded_value = out_bounded;

endmodule

>>> src/lsr_checker.sv
module lsr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       cmd_action,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [lsr_pkg::DATA_W-1:0] result_next_state,
  input logic [lsr_pkg::DATA_W-1:0] result_bounded_value
);

  // a draw keeps the unit busy once accepted
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_action == lsr_pkg::ACTION_DRAW |=> !cmd_ready)
    else $error("unit ready right after accepting a draw");

  // a load leaves the unit ready for the next command
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_action == lsr_pkg::ACTION_LOAD |=> cmd_ready)
    else $error("unit busy right after accepting a load");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_next_state) && $stable(result_bounded_value))
    else $error("stalled result changed");

endmodule

bind lehmer_schrage_rng_unit lsr_checker u_lsr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .cmd_valid           (cmd.valid),
  .cmd_ready           (cmd.ready),
  .cmd_action          (cmd.action),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_next_state   (result.next_state),
  .result_bounded_value(result.bounded_value)
);
